FILE: src/triangle_cotangent_weights_top_assert.svh
// Assertion helpers shared by the triangle cotangent weight block.
`ifndef TRIANGLE_COTANGENT_WEIGHTS_TOP_ASSERT_SVH
`define TRIANGLE_COTANGENT_WEIGHTS_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tcw_pkg.sv
package tcw_pkg;

    // Field and datapath widths.
    localparam int COORD_W     = 32;
    localparam int EDGE_W      = 33;
    localparam int PROD_W      = 66;
    localparam int DOT_W       = 68;
    localparam int CROSS_W     = 67;
    localparam int MAG_W       = 66;
    localparam int HALF_W      = 33;
    localparam int PART_W      = 66;
    localparam int SQR_W       = 132;
    localparam int SUM_W       = 134;
    localparam int WIDE_W      = 196;
    localparam int WGT_W       = 31;

    // Counts.
    localparam int NUM_CORNERS = 3;
    localparam int NUM_AXES    = 3;
    localparam int NUM_PROD    = 9;
    localparam int NUM_TERMS   = 4;
    localparam int NUM_PARTS   = 3;
    localparam int NUM_BITS    = 31;

    localparam logic [WGT_W-1:0] WGT_MAX = '1;
    localparam logic [WGT_W-1:0] WGT_MIN = WGT_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] a_x;
        logic signed [COORD_W-1:0] a_y;
        logic signed [COORD_W-1:0] a_z;
        logic signed [COORD_W-1:0] b_x;
        logic signed [COORD_W-1:0] b_y;
        logic signed [COORD_W-1:0] b_z;
        logic signed [COORD_W-1:0] c_x;
        logic signed [COORD_W-1:0] c_y;
        logic signed [COORD_W-1:0] c_z;
    } tcw_in_t;

    typedef struct packed {
        logic [WGT_W-1:0] weight_bc;
        logic [WGT_W-1:0] weight_ac;
        logic [WGT_W-1:0] weight_ab;
        logic             degenerate;
    } tcw_out_t;

endpackage

FILE: src/triangle_cotangent_weights_top.sv
// Triangle cotangent weights, fully pipelined.
// Stages: 5 arithmetic stages, a search start stage, square-root search stages of one
// weight bit each, and the output register.
// Throughput: one triangle per clock; the whole pipeline advances when the output
// register is empty or being taken. Synchronous active-low reset clears valid bits only.
`include "triangle_cotangent_weights_top_assert.svh"

module triangle_cotangent_weights_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tcw_pkg::tcw_in_t   s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output tcw_pkg::tcw_out_t  m_data
);
    import tcw_pkg::*;

    localparam int T_SHIFT = 2 * FRAC_BITS - 2;
    localparam int NST     = NUM_BITS + 7;
    localparam int CQ [NUM_CORNERS] = '{1, 0, 0};
    localparam int CR [NUM_CORNERS] = '{2, 2, 1};

    logic                      en;
    logic [NST-1:0]            vld_reg, vld_next;

    // Stage registers.
    logic signed [EDGE_W-1:0]  e1_reg [NUM_CORNERS][NUM_AXES];
    logic signed [EDGE_W-1:0]  e1_next [NUM_CORNERS][NUM_AXES];
    logic signed [EDGE_W-1:0]  e2_reg [NUM_CORNERS][NUM_AXES];
    logic signed [EDGE_W-1:0]  e2_next [NUM_CORNERS][NUM_AXES];
    logic signed [PROD_W-1:0]  prod_reg [NUM_CORNERS][NUM_PROD];
    logic signed [PROD_W-1:0]  prod_next [NUM_CORNERS][NUM_PROD];
    logic [MAG_W-1:0]          mag_reg [NUM_CORNERS][NUM_TERMS];
    logic [MAG_W-1:0]          mag_next [NUM_CORNERS][NUM_TERMS];
    logic                      dpos_m_reg [NUM_CORNERS];
    logic                      dpos_m_next [NUM_CORNERS];
    logic [PART_W-1:0]         pp_reg [NUM_CORNERS][NUM_TERMS][NUM_PARTS];
    logic [PART_W-1:0]         pp_next [NUM_CORNERS][NUM_TERMS][NUM_PARTS];
    logic                      dpos_p_reg [NUM_CORNERS];
    logic [SQR_W-1:0]          sqv_reg [NUM_CORNERS][NUM_TERMS];
    logic [SQR_W-1:0]          sqv_next [NUM_CORNERS][NUM_TERMS];
    logic                      dpos_s_reg [NUM_CORNERS];

    // Square-root search registers: a start row and one row per weight bit decided.
    logic [WIDE_W-1:0]         rem_reg [NUM_BITS+1][NUM_CORNERS];
    logic [WIDE_W-1:0]         rem_next [NUM_BITS+1][NUM_CORNERS];
    logic [WIDE_W-1:0]         acc_reg [NUM_BITS+1][NUM_CORNERS];
    logic [WIDE_W-1:0]         acc_next [NUM_BITS+1][NUM_CORNERS];
    logic [SUM_W-1:0]          sq_reg [NUM_BITS+1][NUM_CORNERS];
    logic [SUM_W-1:0]          sq_next [NUM_BITS+1][NUM_CORNERS];
    logic [WGT_W-1:0]          w_reg [NUM_BITS+1][NUM_CORNERS];
    logic [WGT_W-1:0]          w_next [NUM_BITS+1][NUM_CORNERS];
    logic                      pos_reg [NUM_BITS+1][NUM_CORNERS];
    logic                      pos_next [NUM_BITS+1][NUM_CORNERS];
    logic                      deg_reg [NUM_BITS+1][NUM_CORNERS];
    logic                      deg_next [NUM_BITS+1][NUM_CORNERS];

    tcw_out_t                  out_reg, out_next;

    // Combinational helpers.
    logic signed [COORD_W-1:0] pt [NUM_CORNERS][NUM_AXES];
    logic signed [DOT_W-1:0]   dot_c [NUM_CORNERS];
    logic signed [CROSS_W-1:0] crs_c [NUM_CORNERS][NUM_AXES];
    logic signed [CROSS_W-1:0] abs_c [NUM_CORNERS][NUM_AXES];
    logic [HALF_W-1:0]         hi_c [NUM_CORNERS][NUM_TERMS];
    logic [HALF_W-1:0]         lo_c [NUM_CORNERS][NUM_TERMS];
    logic [SUM_W-1:0]          sum_c [NUM_CORNERS];
    logic [WIDE_W-1:0]         inc_c [NUM_BITS][NUM_CORNERS];
    logic [WGT_W-1:0]          wsel_c [NUM_CORNERS];
    logic                      degen_c;

    // The whole pipeline moves when the output register can take a result.
    assign en       = ~vld_reg[NST-1] | m_ready;
    assign s_ready  = en;
    assign m_valid  = vld_reg[NST-1];
    assign m_data   = out_reg;
    assign vld_next = {vld_reg[NST-2:0], s_valid};

    // Datapath next values for every stage.
    always_comb begin
        int b;
        pt[0] = '{s_data.a_x, s_data.a_y, s_data.a_z};
        pt[1] = '{s_data.b_x, s_data.b_y, s_data.b_z};
        pt[2] = '{s_data.c_x, s_data.c_y, s_data.c_z};
        degen_c = 1'b0;
        for (int k = 0; k < NUM_CORNERS; k++) begin
            // Edges leaving the corner.
            for (int i = 0; i < NUM_AXES; i++) begin
                e1_next[k][i] = EDGE_W'(pt[CQ[k]][i]) - EDGE_W'(pt[k][i]);
                e2_next[k][i] = EDGE_W'(pt[CR[k]][i]) - EDGE_W'(pt[k][i]);
            end

            // Products for the dot product and the cross product.
            prod_next[k][0] = PROD_W'(e1_reg[k][0]) * PROD_W'(e2_reg[k][0]);
            prod_next[k][1] = PROD_W'(e1_reg[k][1]) * PROD_W'(e2_reg[k][1]);
            prod_next[k][2] = PROD_W'(e1_reg[k][2]) * PROD_W'(e2_reg[k][2]);
            prod_next[k][3] = PROD_W'(e1_reg[k][1]) * PROD_W'(e2_reg[k][2]);
            prod_next[k][4] = PROD_W'(e1_reg[k][2]) * PROD_W'(e2_reg[k][1]);
            prod_next[k][5] = PROD_W'(e1_reg[k][2]) * PROD_W'(e2_reg[k][0]);
            prod_next[k][6] = PROD_W'(e1_reg[k][0]) * PROD_W'(e2_reg[k][2]);
            prod_next[k][7] = PROD_W'(e1_reg[k][0]) * PROD_W'(e2_reg[k][1]);
            prod_next[k][8] = PROD_W'(e1_reg[k][1]) * PROD_W'(e2_reg[k][0]);

            // Dot product and magnitudes of the cross product components.
            dot_c[k] = DOT_W'(prod_reg[k][0]) + DOT_W'(prod_reg[k][1])
                     + DOT_W'(prod_reg[k][2]);
            crs_c[k][0] = CROSS_W'(prod_reg[k][3]) - CROSS_W'(prod_reg[k][4]);
            crs_c[k][1] = CROSS_W'(prod_reg[k][5]) - CROSS_W'(prod_reg[k][6]);
            crs_c[k][2] = CROSS_W'(prod_reg[k][7]) - CROSS_W'(prod_reg[k][8]);
            dpos_m_next[k] = !dot_c[k][DOT_W-1] && (dot_c[k] != '0);
            mag_next[k][0] = dot_c[k][MAG_W-1:0];
            for (int i = 0; i < NUM_AXES; i++) begin
                abs_c[k][i] = crs_c[k][i][CROSS_W-1] ? -crs_c[k][i] : crs_c[k][i];
                mag_next[k][i+1] = abs_c[k][i][MAG_W-1:0];
            end

            // Squares split into half-width partial products.
            for (int t = 0; t < NUM_TERMS; t++) begin
                hi_c[k][t] = mag_reg[k][t][MAG_W-1:HALF_W];
                lo_c[k][t] = mag_reg[k][t][HALF_W-1:0];
                pp_next[k][t][0] = PART_W'(hi_c[k][t]) * PART_W'(hi_c[k][t]);
                pp_next[k][t][1] = PART_W'(hi_c[k][t]) * PART_W'(lo_c[k][t]);
                pp_next[k][t][2] = PART_W'(lo_c[k][t]) * PART_W'(lo_c[k][t]);
                sqv_next[k][t] = (SQR_W'(pp_reg[k][t][0]) << (2 * HALF_W))
                               + (SQR_W'(pp_reg[k][t][1]) << (HALF_W + 1))
                               + SQR_W'(pp_reg[k][t][2]);
            end

            // Search start: remainder is the scaled squared dot product.
            sum_c[k] = SUM_W'(sqv_reg[k][1]) + SUM_W'(sqv_reg[k][2])
                     + SUM_W'(sqv_reg[k][3]);
            rem_next[0][k] = WIDE_W'(sqv_reg[k][0]) << T_SHIFT;
            acc_next[0][k] = '0;
            sq_next[0][k]  = sum_c[k];
            w_next[0][k]   = '0;
            pos_next[0][k] = dpos_s_reg[k];
            deg_next[0][k] = (sum_c[k] == '0);

            // One weight bit per stage: keep rem = T - w^2 * S and acc = w * S.
            for (int j = 0; j < NUM_BITS; j++) begin
                b = NUM_BITS - 1 - j;
                inc_c[j][k] = (acc_reg[j][k] << (b + 1))
                            + (WIDE_W'(sq_reg[j][k]) << (2 * b));
                sq_next[j+1][k]  = sq_reg[j][k];
                pos_next[j+1][k] = pos_reg[j][k];
                deg_next[j+1][k] = deg_reg[j][k];
                if (inc_c[j][k] <= rem_reg[j][k]) begin
                    rem_next[j+1][k] = rem_reg[j][k] - inc_c[j][k];
                    acc_next[j+1][k] = acc_reg[j][k] + (WIDE_W'(sq_reg[j][k]) << b);
                    w_next[j+1][k]   = w_reg[j][k] | (WGT_W'(1) << b);
                end else begin
                    rem_next[j+1][k] = rem_reg[j][k];
                    acc_next[j+1][k] = acc_reg[j][k];
                    w_next[j+1][k]   = w_reg[j][k];
                end
            end
            degen_c = degen_c | deg_reg[NUM_BITS][k];
        end

        // Clamp and saturate the final weights.
        for (int k = 0; k < NUM_CORNERS; k++) begin
            if (degen_c) begin
                wsel_c[k] = WGT_MAX;
            end else if (!pos_reg[NUM_BITS][k] || (w_reg[NUM_BITS][k] == '0)) begin
                wsel_c[k] = WGT_MIN;
            end else begin
                wsel_c[k] = w_reg[NUM_BITS][k];
            end
        end
        out_next.weight_bc  = wsel_c[0];
        out_next.weight_ac  = wsel_c[1];
        out_next.weight_ab  = wsel_c[2];
        out_next.degenerate = degen_c;
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (en) begin
            e1_reg     <= e1_next;
            e2_reg     <= e2_next;
            prod_reg   <= prod_next;
            mag_reg    <= mag_next;
            dpos_m_reg <= dpos_m_next;
            pp_reg     <= pp_next;
            dpos_p_reg <= dpos_m_reg;
            sqv_reg    <= sqv_next;
            dpos_s_reg <= dpos_p_reg;
            rem_reg    <= rem_next;
            acc_reg    <= acc_next;
            sq_reg     <= sq_next;
            w_reg      <= w_next;
            pos_reg    <= pos_next;
            deg_reg    <= deg_next;
            out_reg    <= out_next;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    // A degenerate triangle saturates all three weights.
    `TCW_ASSERT_SAME(a_degen_sat, m_valid && m_data.degenerate, m_data.weight_bc == WGT_MAX && m_data.weight_ac == WGT_MAX && m_data.weight_ab == WGT_MAX, "degenerate result without saturated weights")
    // Every regular weight is at least one LSB.
    `TCW_ASSERT_SAME(a_wgt_min, m_valid && !m_data.degenerate, m_data.weight_bc != '0 && m_data.weight_ac != '0 && m_data.weight_ab != '0, "weight below one LSB")
    // An empty output register never blocks requests.
    `TCW_ASSERT_SAME(a_ready_empty, !m_valid, s_ready, "request blocked with empty output")
    // An accepted request occupies the first stage.
    `TCW_ASSERT_NEXT(a_accept_enters, s_valid && s_ready, vld_reg[0], "accepted request lost")

endmodule
